// ===== src/ps2_mouse_cursor_tracker_unit_macros.svh =====
// assertion macros for the cursor tracker
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PS2MCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ps2mct assertion failed");

`define PS2MCT_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  `PS2MCT_ASSERT(lbl, clk, rst_n, !(prop))

`else

`define PS2MCT_ASSERT(lbl, clk, rst_n, prop)

`define PS2MCT_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

// ===== src/ps2mct_pkg.sv =====
package ps2mct_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0]  StatusReady = 8'h01;
  localparam logic [ByteW-1:0]  StatusAux   = 8'h20;
  localparam logic [IdxW-1:0]   IdxXMove    = 2'd1;
  localparam logic [IdxW-1:0]   IdxLast     = 2'd2;
  localparam logic [CoordW-1:0] CursorW     = 12'd12;
  localparam logic [CoordW-1:0] CursorH     = 12'd19;
  localparam logic [CoordW-1:0] PosXReset   = 12'd400;
  localparam logic [CoordW-1:0] PosYReset   = 12'd300;
  localparam logic [CoordW-1:0] WidthReset  = 12'd800;
  localparam logic [CoordW-1:0] HeightReset = 12'd600;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenWidth  = 2'd0,
    CfgScreenHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] cursor_x;
    logic [CoordW-1:0] cursor_y;
    logic              byte_taken;
    logic              packet_done;
  } out_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   byte_index;
    logic [ByteW-1:0]  x_move_byte;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
  } track_state_t;

  typedef struct packed {
    logic [CoordW-1:0] disp_width;
    logic [CoordW-1:0] disp_height;
  } screen_cfg_t;

endpackage

// ===== src/ps2mct_step.sv =====
module ps2mct_step (
  input  ps2mct_pkg::in_item_t     item_i,
  input  ps2mct_pkg::track_state_t state_i,
  input  ps2mct_pkg::screen_cfg_t  cfg_i,
  output ps2mct_pkg::track_state_t state_o,
  output ps2mct_pkg::out_item_t    result_o
);

  logic                                  taken;
  logic                                  done;
  logic signed [ps2mct_pkg::ByteW:0]     dx;
  logic signed [ps2mct_pkg::ByteW:0]     dy;
  logic signed [ps2mct_pkg::CoordW+1:0]  nx;
  logic signed [ps2mct_pkg::CoordW+1:0]  ny;
  logic [ps2mct_pkg::CoordW-1:0]         lim_x;
  logic [ps2mct_pkg::CoordW-1:0]         lim_y;
  logic [ps2mct_pkg::CoordW-1:0]         clamp_x;
  logic [ps2mct_pkg::CoordW-1:0]         clamp_y;

  assign taken = ((item_i.status_byte & ps2mct_pkg::StatusReady) != '0) &&
                 ((item_i.status_byte & ps2mct_pkg::StatusAux) != '0);
  assign done  = taken && (state_i.byte_index >= ps2mct_pkg::IdxLast);

  // halve with truncation toward zero
  assign dx = ($signed({state_i.x_move_byte[7], state_i.x_move_byte}) +
               $signed({8'd0, state_i.x_move_byte[7]})) >>> 1;
  assign dy = ($signed({item_i.data_byte[7], item_i.data_byte}) +
               $signed({8'd0, item_i.data_byte[7]})) >>> 1;

  assign nx = $signed({2'b00, state_i.pos_x}) + 14'(dx);
  assign ny = $signed({2'b00, state_i.pos_y}) - 14'(dy);

  assign lim_x = (cfg_i.disp_width < ps2mct_pkg::CursorW) ? '0 :
                 cfg_i.disp_width - ps2mct_pkg::CursorW;
  assign lim_y = (cfg_i.disp_height < ps2mct_pkg::CursorH) ? '0 :
                 cfg_i.disp_height - ps2mct_pkg::CursorH;

  always_comb begin
    if (nx[13]) begin
      clamp_x = '0;
    end else if (nx[12:0] > {1'b0, lim_x}) begin
      clamp_x = lim_x;
    end else begin
      clamp_x = nx[11:0];
    end
    if (ny[13]) begin
      clamp_y = '0;
    end else if (ny[12:0] > {1'b0, lim_y}) begin
      clamp_y = lim_y;
    end else begin
      clamp_y = ny[11:0];
    end
  end

  always_comb begin
    state_o = state_i;
    if (taken) begin
      if (state_i.byte_index == ps2mct_pkg::IdxXMove) begin
        state_o.x_move_byte = item_i.data_byte;
      end
      if (done) begin
        state_o.byte_index = '0;
        state_o.pos_x      = clamp_x;
        state_o.pos_y      = clamp_y;
      end else begin
        state_o.byte_index = state_i.byte_index + 2'd1;
      end
    end
  end

  assign result_o.cursor_x    = state_o.pos_x;
  assign result_o.cursor_y    = state_o.pos_y;
  assign result_o.byte_taken  = taken;
  assign result_o.packet_done = done;

endmodule

// ===== src/ps2_mouse_cursor_tracker_unit.sv =====
// an accepted input item is held in the input register, then its result in the result register
// throughput: one item per cycle while the output is not stalled, set by the single add-and-clamp stage
// a stalled output holds one result while the input register takes one more item
// reset: cursor at 400,300, packet index 0, screen 800 x 600, both stages empty
// configuration writes are taken every cycle and apply at the next completed packet
`include "ps2_mouse_cursor_tracker_unit_macros.svh"

module ps2_mouse_cursor_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ps2mct_pkg::in_item_t               in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ps2mct_pkg::out_item_t              out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ps2mct_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ps2mct_pkg::CoordW-1:0]      cfg_data_i
);

  ps2mct_pkg::in_item_t     in_q;
  logic                     in_valid_q;
  ps2mct_pkg::out_item_t    out_q;
  ps2mct_pkg::out_item_t    out_d;
  logic                     out_valid_q;
  ps2mct_pkg::track_state_t state_q;
  ps2mct_pkg::track_state_t state_d;
  ps2mct_pkg::screen_cfg_t  cfg_q;
  logic                     advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  ps2mct_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{byte_index: '0, x_move_byte: '0,
                       pos_x: ps2mct_pkg::PosXReset, pos_y: ps2mct_pkg::PosYReset};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disp_width  <= ps2mct_pkg::WidthReset;
      cfg_q.disp_height <= ps2mct_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ps2mct_pkg::CfgScreenWidth:  cfg_q.disp_width  <= cfg_data_i;
        ps2mct_pkg::CfgScreenHeight: cfg_q.disp_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `PS2MCT_ASSERT_NEVER(a_index_range, clk_i, rst_ni, state_q.byte_index == 2'd3)
  `PS2MCT_ASSERT(a_done_taken, clk_i, rst_ni,
    out_valid_q && out_q.packet_done |-> out_q.byte_taken)
  `PS2MCT_ASSERT(a_idle_hold, clk_i, rst_ni,
    advance && !out_d.packet_done |=> $stable(state_q.pos_x) && $stable(state_q.pos_y))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

import ps2mct_pkg::*;

class cursor_track_checker;
  logic [IdxW-1:0]   pkt_pos;
  logic [ByteW-1:0]  held_x;
  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic [CoordW-1:0] width;
  logic [CoordW-1:0] height;
  out_item_t         reports_due[$];
  int n_items, n_taken, n_packets, n_cfg, n_fail;
  int x_at_low, x_at_high, y_at_low, y_at_high;

  function new();
    pkt_pos = '0;
    held_x  = '0;
    cur_x   = PosXReset;
    cur_y   = PosYReset;
    width   = WidthReset;
    height  = HeightReset;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [CoordW-1:0] val);
    case (idx)
      CfgScreenWidth: begin
        width = val;
      end
      CfgScreenHeight: begin
        height = val;
      end
      default: begin
      end
    endcase
    n_cfg++;
  endfunction

  static function int clamp_to_screen(int v, int lim);
    if (lim < 0) lim = 0;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  function void take_byte_item(in_item_t it);
    out_item_t rep;
    logic      taken;
    logic      done;
    int        lim_x;
    int        lim_y;
    taken = ((it.status_byte & StatusReady) != '0) && ((it.status_byte & StatusAux) != '0);
    done  = 1'b0;
    lim_x = int'(width) - int'(CursorW);
    lim_y = int'(height) - int'(CursorH);
    if (taken) begin
      n_taken++;
      if (pkt_pos == IdxXMove) held_x = it.data_byte;
      if (pkt_pos >= IdxLast) begin
        // moves are halved toward zero, y axis runs opposite to the mouse
        cur_x = CoordW'(clamp_to_screen(int'(cur_x) + (int'($signed(held_x)) / 2), lim_x));
        cur_y = CoordW'(clamp_to_screen(int'(cur_y) - (int'($signed(it.data_byte)) / 2),
                                        lim_y));
        pkt_pos = '0;
        done    = 1'b1;
        n_packets++;
        if (cur_x == '0) x_at_low++;
        if (lim_x > 0 && int'(cur_x) == lim_x) x_at_high++;
        if (cur_y == '0) y_at_low++;
        if (lim_y > 0 && int'(cur_y) == lim_y) y_at_high++;
      end else begin
        pkt_pos = pkt_pos + 1'b1;
      end
    end
    rep.cursor_x    = cur_x;
    rep.cursor_y    = cur_y;
    rep.byte_taken  = taken;
    rep.packet_done = done;
    reports_due.push_back(rep);
    n_items++;
  endfunction

  function void check_cursor_report(out_item_t got);
    out_item_t want;
    if (reports_due.size() == 0) begin
      $error("cursor report with none outstanding: x %0d y %0d", got.cursor_x, got.cursor_y);
      n_fail++;
      return;
    end
    want = reports_due.pop_front();
    if (got.cursor_x !== want.cursor_x) begin
      $error("cursor_x expected %0d actual %0d", want.cursor_x, got.cursor_x);
      n_fail++;
    end
    if (got.cursor_y !== want.cursor_y) begin
      $error("cursor_y expected %0d actual %0d", want.cursor_y, got.cursor_y);
      n_fail++;
    end
    if (got.byte_taken !== want.byte_taken) begin
      $error("byte_taken expected %0d actual %0d", want.byte_taken, got.byte_taken);
      n_fail++;
    end
    if (got.packet_done !== want.packet_done) begin
      $error("packet_done expected %0d actual %0d", want.packet_done, got.packet_done);
      n_fail++;
    end
  endfunction
endclass

module tb_top;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam logic [ByteW-1:0] TakeBoth = StatusReady | StatusAux;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0]  cfg_data_i  = '0;

  cursor_track_checker tracker = new();
  int cycle_count = 0;
  bit send_eager  = 1'b0;
  bit recv_eager  = 1'b0;

  ps2_mouse_cursor_tracker_unit u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [ByteW-1:0] draw_move(int bias);
    case (bias)
      1:       return ByteW'($urandom_range(64, 127));
      -1:      return ByteW'($urandom_range(128, 192));
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t taken_item(logic [ByteW-1:0] d);
    in_item_t it;
    it.status_byte = ByteW'($urandom_range(0, 255)) | TakeBoth;
    it.data_byte   = d;
    return it;
  endfunction

  function automatic in_item_t ignored_item();
    in_item_t it;
    it.status_byte = ByteW'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0:       it.status_byte &= ~StatusReady;
      1:       it.status_byte &= ~StatusAux;
      default: it.status_byte &= ~TakeBoth;
    endcase
    it.data_byte = ByteW'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) send_eager = !send_eager;
    gap = send_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_byte_item(it);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send_item(ignored_item());
  endtask

  // header, x move, y move; some packets are cut short and the next one
  // first tops up the broken packet with random bytes
  task automatic drive_packets(int count, int bx, int by);
    repeat (count) begin
      while (tracker.pkt_pos != '0) send_item(taken_item(ByteW'($urandom_range(0, 255))));
      send_item(taken_item(ByteW'($urandom_range(0, 255))));
      maybe_noise();
      send_item(taken_item(draw_move(bx)));
      if ($urandom_range(0, 19) != 0) begin
        maybe_noise();
        send_item(taken_item(draw_move(by)));
      end
    end
  endtask

  task automatic wander(int count);
    int seg;
    while (count > 0) begin
      seg = $urandom_range(5, 25);
      if (seg > count) seg = count;
      drive_packets(seg, int'($urandom_range(0, 2)) - 1, int'($urandom_range(0, 2)) - 1);
      count -= seg;
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CoordW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(logic [CoordW-1:0] w, logic [CoordW-1:0] h);
    in_valid_i <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    write_reg(CfgScreenWidth, w);
    write_reg(CfgScreenHeight, h);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    in_item_t seq[$] = '{
      in_item_t'{8'h00, 8'hFF},
      in_item_t'{StatusReady, 8'h5A},
      in_item_t'{StatusAux, 8'hA5},
      in_item_t'{~StatusReady, 8'h00},
      in_item_t'{~StatusAux, 8'hFF},
      // full right, full down
      in_item_t'{8'hFF, 8'hFF},
      in_item_t'{TakeBoth, 8'h7F},
      in_item_t'{TakeBoth, 8'h80},
      in_item_t'{TakeBoth, 8'h00},
      in_item_t'{TakeBoth, 8'h81},
      in_item_t'{TakeBoth, 8'h7F},
      // header overflow bits ignored, minus one halves to zero
      in_item_t'{TakeBoth | 8'hC0, 8'hC8},
      in_item_t'{TakeBoth, 8'hFF},
      in_item_t'{TakeBoth, 8'h01},
      in_item_t'{TakeBoth, 8'h08},
      in_item_t'{TakeBoth, 8'hFE},
      in_item_t'{8'h00, 8'h55},
      in_item_t'{TakeBoth, 8'hFF},
      in_item_t'{TakeBoth, 8'h18},
      in_item_t'{StatusAux, 8'h40},
      in_item_t'{TakeBoth, 8'h03},
      in_item_t'{StatusReady, 8'hC0},
      in_item_t'{TakeBoth, 8'hFD}
    };
    foreach (seq[i]) send_item(seq[i]);
  endtask

  initial begin : result_sink
    int gap;
    int got;
    got = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_eager = !recv_eager;
      gap = recv_eager ? 0 : $urandom_range(0, 14);
      // long back-pressure so the input side has to stall
      if (got == 300 || got == 1000) gap = HoldCycles;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      tracker.check_cursor_report(out_item_o);
      got++;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wander(80);
    configure('1, '1);
    drive_packets(15, -1, 1);
    drive_packets(90, 1, -1);
    // cursor sits far beyond the new limit until the next packet
    configure(12'd0, 12'd0);
    wander(20);
    configure(12'd11, 12'd18);
    wander(20);
    configure(12'd12, 12'd19);
    wander(20);
    configure(12'd100, 12'd50);
    wander(50);
    repeat (2) begin
      configure(CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)));
      wander(50);
    end
    configure(WidthReset, HeightReset);
    wander(50);
    in_valid_i <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("run covered %0d items, %0d bytes taken, %0d packets, %0d register writes",
             tracker.n_items, tracker.n_taken, tracker.n_packets, tracker.n_cfg);
    $display("packets ending on a screen edge: left %0d right %0d top %0d bottom %0d",
             tracker.x_at_low, tracker.x_at_high, tracker.y_at_low, tracker.y_at_high);
    if (tracker.n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== ps2_mouse_cursor_tracker_unit.f =====
+incdir+src
src/ps2mct_pkg.sv
src/ps2mct_step.sv
src/ps2_mouse_cursor_tracker_unit.sv
tb/sv/tb_top.sv
